// ----- rtl/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants for the LRU block buffer cache
// Field widths, operation and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int SLOT_COUNT_DEF = 32;

	localparam int FUNC_W = 2;
	localparam int DEV_W  = 8;
	localparam int BLK_W  = 32;
	localparam int SLOT_W = 5;
	localparam int CNT_W  = 8;
	localparam int STAT_W = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ACQUIRE = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_PIN     = 2'd2,
		FUNC_UNPIN   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_DISPATCH   = 7'b0000010,
		ST_ACQ_SCAN   = 7'b0000100,
		ST_ACQ_COMMIT = 7'b0001000,
		ST_OP_COMMIT  = 7'b0010000,
		ST_SWEEP      = 7'b0100000,
		ST_DONE       = 7'b1000000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic scan_clr;
		logic scan_rd;
		logic slot_rd;
		logic track;
		logic sweep_en;
		logic acq_commit;
		logic op_commit;
		logic echo;
		logic out_load;
	} lbc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_acq;
		logic in_range;
		logic scan_end;
		logic rd_vld;
		logic sweep_need;
		logic out_free;
	} lbc_sts_t;

endpackage

// ----- rtl/lbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbc_ctrl: sequencing state machine
// Takes one request word at a time, steps the datapath through the slot
// table scans and commits, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lbc_pkg::lbc_sts_t sts,
	output lbc_pkg::lbc_cmd_t cmd
);

	lbc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == lbc_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			lbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = lbc_pkg::ST_DISPATCH;
				end
			end
			lbc_pkg::ST_DISPATCH: begin
				if (sts.is_acq) begin
					cmd.scan_clr = 1'b1;
					state_d      = lbc_pkg::ST_ACQ_SCAN;
				end else if (!sts.in_range) begin
					cmd.echo = 1'b1;
					state_d  = lbc_pkg::ST_DONE;
				end else begin
					cmd.slot_rd = 1'b1;
					state_d     = lbc_pkg::ST_OP_COMMIT;
				end
			end
			lbc_pkg::ST_ACQ_SCAN: begin
				cmd.track = 1'b1;
				if (!sts.scan_end) begin
					cmd.scan_rd = 1'b1;
				end else if (!sts.rd_vld) begin
					state_d = lbc_pkg::ST_ACQ_COMMIT;
				end
			end
			lbc_pkg::ST_ACQ_COMMIT: begin
				cmd.acq_commit = 1'b1;
				state_d        = lbc_pkg::ST_DONE;
			end
			lbc_pkg::ST_OP_COMMIT: begin
				cmd.op_commit = 1'b1;
				// release that drops the count to zero: re-rank every slot
				if (sts.sweep_need) begin
					cmd.scan_clr = 1'b1;
					state_d      = lbc_pkg::ST_SWEEP;
				end else begin
					state_d = lbc_pkg::ST_DONE;
				end
			end
			lbc_pkg::ST_SWEEP: begin
				cmd.sweep_en = 1'b1;
				if (!sts.scan_end) begin
					cmd.scan_rd = 1'b1;
				end else if (!sts.rd_vld) begin
					state_d = lbc_pkg::ST_DONE;
				end
			end
			lbc_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = lbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lbc_pkg::ST_IDLE;
			end
		endcase
	end

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_commit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lbc_pkg::ST_ACQ_COMMIT) |-> $past(sts.scan_end) && !$past(sts.rd_vld))
		else $error("acquire committed before scan drained");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> (state_q == lbc_pkg::ST_DISPATCH))
		else $error("accepted word not dispatched");

endmodule

// ----- rtl/lbc_dpath.sv -----
// ----------------------------------------------------------------------------
// lbc_dpath: slot table, scan trackers and result registers
// Holds the slot table memory with a per-slot written flag, one registered
// read port and one write port, the hit and free-slot trackers for acquire,
// the re-rank sweep for release, and the output register.
// ----------------------------------------------------------------------------
module lbc_dpath #(
	parameter int SLOT_COUNT = lbc_pkg::SLOT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lbc_pkg::lbc_cmd_t                cmd,
	output lbc_pkg::lbc_sts_t                sts,
	input  logic [lbc_pkg::FUNC_W-1:0]       in_func,
	input  logic [lbc_pkg::DEV_W-1:0]        in_device_id,
	input  logic [lbc_pkg::BLK_W-1:0]        in_block_number,
	input  logic [lbc_pkg::SLOT_W-1:0]       in_slot_index,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [lbc_pkg::SLOT_W-1:0]       out_slot,
	output logic                             out_hit,
	output logic                             out_need_read,
	output logic [lbc_pkg::STAT_W-1:0]       out_status
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [IW-1:0] RANK_TOP = IW'(SLOT_COUNT - 1);

	// request
	logic [lbc_pkg::FUNC_W-1:0] func_q;
	logic [lbc_pkg::DEV_W-1:0]  dev_q;
	logic [lbc_pkg::BLK_W-1:0]  blk_q;
	logic [lbc_pkg::SLOT_W-1:0] slot_q;
	logic [IW-1:0]              slot_idx;

	// slot table
	logic [lbc_pkg::DEV_W-1:0] mem_dev  [SLOT_COUNT];
	logic [lbc_pkg::BLK_W-1:0] mem_blk  [SLOT_COUNT];
	logic                      mem_val  [SLOT_COUNT];
	logic [lbc_pkg::CNT_W-1:0] mem_cnt  [SLOT_COUNT];
	logic [IW-1:0]             mem_rank [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]     init_q;

	logic                      rd_en;
	logic [IW-1:0]             rd_addr;
	logic                      rd_vld_s1;
	logic                      rd_init_s1;
	logic [IW-1:0]             rd_idx_s1;
	logic [lbc_pkg::DEV_W-1:0] rd_dev_s1;
	logic [lbc_pkg::BLK_W-1:0] rd_blk_s1;
	logic                      rd_val_s1;
	logic [lbc_pkg::CNT_W-1:0] rd_cnt_s1;
	logic [IW-1:0]             rd_rank_s1;

	logic [lbc_pkg::DEV_W-1:0] e_dev;
	logic [lbc_pkg::BLK_W-1:0] e_blk;
	logic                      e_val;
	logic [lbc_pkg::CNT_W-1:0] e_cnt;
	logic [IW-1:0]             e_rank;

	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	logic [lbc_pkg::DEV_W-1:0] wr_dev;
	logic [lbc_pkg::BLK_W-1:0] wr_blk;
	logic                      wr_val;
	logic [lbc_pkg::CNT_W-1:0] wr_cnt;
	logic [IW-1:0]             wr_rank;

	logic [CW-1:0] scan_q;

	// trackers
	logic                      hit_fnd_q;
	logic [IW-1:0]             hit_idx_q;
	logic [IW-1:0]             hit_rank_q;
	logic [lbc_pkg::CNT_W-1:0] hit_cnt_q;
	logic                      hit_val_q;
	logic                      free_fnd_q;
	logic [IW-1:0]             free_idx_q;
	logic [IW-1:0]             free_rank_q;
	logic [IW-1:0]             sweep_rank_q;

	logic tag_match;
	logic hit_ovf;
	logic op_is_pin;
	logic op_err;
	logic [lbc_pkg::CNT_W-1:0] op_cnt_nxt;

	// result and output registers
	logic [lbc_pkg::SLOT_W-1:0] res_slot_q;
	logic                       res_hit_q;
	logic                       res_need_q;
	logic [lbc_pkg::STAT_W-1:0] res_status_q;
	logic                       out_vld_q;
	logic [lbc_pkg::SLOT_W-1:0] out_slot_q;
	logic                       out_hit_q;
	logic                       out_need_q;
	logic [lbc_pkg::STAT_W-1:0] out_status_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= in_func;
			dev_q  <= in_device_id;
			blk_q  <= in_block_number;
			slot_q <= in_slot_index;
		end
	end

	assign slot_idx = IW'(slot_q);

	// scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_rd) begin
			scan_q <= scan_q + CW'(1);
		end
	end

	assign rd_en   = cmd.scan_rd | cmd.slot_rd;
	assign rd_addr = cmd.slot_rd ? slot_idx : scan_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_init_s1 <= init_q[rd_addr];
			rd_idx_s1  <= rd_addr;
			rd_dev_s1  <= mem_dev[rd_addr];
			rd_blk_s1  <= mem_blk[rd_addr];
			rd_val_s1  <= mem_val[rd_addr];
			rd_cnt_s1  <= mem_cnt[rd_addr];
			rd_rank_s1 <= mem_rank[rd_addr];
		end
	end

	// unwritten slots read as their reset contents
	assign e_dev  = rd_init_s1 ? rd_dev_s1 : '0;
	assign e_blk  = rd_init_s1 ? rd_blk_s1 : '0;
	assign e_val  = rd_init_s1 ? rd_val_s1 : 1'b0;
	assign e_cnt  = rd_init_s1 ? rd_cnt_s1 : '0;
	assign e_rank = rd_init_s1 ? rd_rank_s1 : (RANK_TOP - rd_idx_s1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_dev[wr_addr]  <= wr_dev;
			mem_blk[wr_addr]  <= wr_blk;
			mem_val[wr_addr]  <= wr_val;
			mem_cnt[wr_addr]  <= wr_cnt;
			mem_rank[wr_addr] <= wr_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (wr_en) begin
			init_q[wr_addr] <= 1'b1;
		end
	end

	assign tag_match = (e_dev == dev_q) && (e_blk == blk_q);

	// hit: lowest rank among matches; free: highest rank among zero counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
		end else if (cmd.track && rd_vld_s1) begin
			if (tag_match && (!hit_fnd_q || e_rank < hit_rank_q)) begin
				hit_fnd_q <= 1'b1;
			end
			if ((e_cnt == '0) && (!free_fnd_q || e_rank > free_rank_q)) begin
				free_fnd_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.track && rd_vld_s1) begin
			if (tag_match && (!hit_fnd_q || e_rank < hit_rank_q)) begin
				hit_idx_q  <= rd_idx_s1;
				hit_rank_q <= e_rank;
				hit_cnt_q  <= e_cnt;
				hit_val_q  <= e_val;
			end
			if ((e_cnt == '0) && (!free_fnd_q || e_rank > free_rank_q)) begin
				free_idx_q  <= rd_idx_s1;
				free_rank_q <= e_rank;
			end
		end
		if (cmd.op_commit) begin
			sweep_rank_q <= e_rank;
		end
	end

	assign hit_ovf    = (hit_cnt_q == lbc_pkg::CNT_MAX);
	assign op_is_pin  = (func_q == lbc_pkg::FUNC_PIN);
	assign op_err     = op_is_pin ? (e_cnt == lbc_pkg::CNT_MAX) : (e_cnt == '0);
	assign op_cnt_nxt = op_is_pin ? (e_cnt + lbc_pkg::CNT_W'(1))
		: (e_cnt - lbc_pkg::CNT_W'(1));

	// single write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_dev  = dev_q;
		wr_blk  = blk_q;
		wr_val  = 1'b1;
		wr_cnt  = hit_cnt_q + lbc_pkg::CNT_W'(1);
		wr_rank = hit_rank_q;
		if (cmd.acq_commit) begin
			if (hit_fnd_q) begin
				wr_en = !hit_ovf;
			end else if (free_fnd_q) begin
				wr_en   = 1'b1;
				wr_addr = free_idx_q;
				wr_cnt  = lbc_pkg::CNT_W'(1);
				wr_rank = free_rank_q;
			end
		end else if (cmd.op_commit) begin
			wr_en   = !op_err && !sts.sweep_need;
			wr_addr = slot_idx;
			wr_dev  = e_dev;
			wr_blk  = e_blk;
			wr_val  = e_val;
			wr_cnt  = op_cnt_nxt;
			wr_rank = e_rank;
		end else if (cmd.sweep_en) begin
			wr_en   = rd_vld_s1;
			wr_addr = rd_idx_s1;
			wr_dev  = e_dev;
			wr_blk  = e_blk;
			wr_val  = e_val;
			if (rd_idx_s1 == slot_idx) begin
				wr_cnt  = e_cnt - lbc_pkg::CNT_W'(1);
				wr_rank = '0;
			end else begin
				wr_cnt  = e_cnt;
				wr_rank = (e_rank < sweep_rank_q) ? (e_rank + IW'(1)) : e_rank;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acq_commit) begin
			if (hit_fnd_q) begin
				res_slot_q   <= lbc_pkg::SLOT_W'(hit_idx_q);
				res_hit_q    <= 1'b1;
				res_need_q   <= !hit_ovf && !hit_val_q;
				res_status_q <= hit_ovf ? lbc_pkg::STAT_OVERFLOW : lbc_pkg::STAT_OK;
			end else if (free_fnd_q) begin
				res_slot_q   <= lbc_pkg::SLOT_W'(free_idx_q);
				res_hit_q    <= 1'b0;
				res_need_q   <= 1'b1;
				res_status_q <= lbc_pkg::STAT_OK;
			end else begin
				res_slot_q   <= '0;
				res_hit_q    <= 1'b0;
				res_need_q   <= 1'b0;
				res_status_q <= lbc_pkg::STAT_NO_FREE;
			end
		end else if (cmd.op_commit) begin
			res_slot_q <= slot_q;
			res_hit_q  <= 1'b0;
			res_need_q <= 1'b0;
			if (!op_err) begin
				res_status_q <= lbc_pkg::STAT_OK;
			end else if (op_is_pin) begin
				res_status_q <= lbc_pkg::STAT_OVERFLOW;
			end else begin
				res_status_q <= lbc_pkg::STAT_UNDERFLOW;
			end
		end else if (cmd.echo) begin
			res_slot_q   <= slot_q;
			res_hit_q    <= 1'b0;
			res_need_q   <= 1'b0;
			res_status_q <= lbc_pkg::STAT_OK;
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_slot_q   <= res_slot_q;
			out_hit_q    <= res_hit_q;
			out_need_q   <= res_need_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid     = out_vld_q;
	assign out_slot      = out_slot_q;
	assign out_hit       = out_hit_q;
	assign out_need_read = out_need_q;
	assign out_status    = out_status_q;

	assign sts.is_acq     = (func_q == lbc_pkg::FUNC_ACQUIRE);
	assign sts.in_range   = ({27'd0, slot_q} < 32'(SLOT_COUNT));
	assign sts.scan_end   = (scan_q == CW'(SLOT_COUNT));
	assign sts.rd_vld     = rd_vld_s1;
	assign sts.sweep_need = (func_q == lbc_pkg::FUNC_RELEASE) && (e_cnt == lbc_pkg::CNT_W'(1));
	assign sts.out_free   = !out_vld_q || out_ready;

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write to the same slot in one cycle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> ({{(32-CW){1'b0}}, scan_q} < 32'(SLOT_COUNT)))
		else $error("scan read past the last slot");

	a_acq_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acq_commit |-> !rd_vld_s1)
		else $error("acquire commit with a read still in flight");

endmodule

// ----- rtl/lru_block_buffer_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit: LRU block buffer cache with reference counts
// Acquire, release, pin and unpin on a table of buffer slots.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  func, device_id, block_number,
//                                              slot_index
//  m_axis    out  m_axis_tvalid/m_axis_tready  slot_out, hit, need_read, status
//
// Acquire scans the whole table from accept to result: one read a cycle
// through the slot table's single read port, then one commit.
// Release to a zero count re-ranks every slot.
// Other requests touch only their own slot, or none for an index past the table.
// One request is in progress at a time.
// Reset leaves the table at its reset contents at once (per-slot written flags).
// A result holds in the output register until taken; the next word is accepted
// meanwhile, and its result waits for the register to empty.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_unit #(
	parameter int SLOT_COUNT = lbc_pkg::SLOT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] func, [9:2] device_id, [41:10] block_number, [46:42] slot_index
	input  logic [lbc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [4:0] slot_out, [5] hit, [6] need_read, [8:7] status
	output logic [lbc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	lbc_pkg::lbc_cmd_t cmd;
	lbc_pkg::lbc_sts_t sts;

	logic [lbc_pkg::SLOT_W-1:0] out_slot;
	logic                       out_hit;
	logic                       out_need_read;
	logic [lbc_pkg::STAT_W-1:0] out_status;

	lbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbc_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_func         (s_axis_tdata[1:0]),
		.in_device_id    (s_axis_tdata[9:2]),
		.in_block_number (s_axis_tdata[41:10]),
		.in_slot_index   (s_axis_tdata[46:42]),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_slot        (out_slot),
		.out_hit         (out_hit),
		.out_need_read   (out_need_read),
		.out_status      (out_status)
	);

	assign m_axis_tdata = {7'd0, out_status, out_need_read, out_hit, out_slot};

endmodule

// ----- sim/tb_lru_block_buffer_cache_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lru_block_buffer_cache_unit: self-checking bench for the LRU buffer cache
// Drives acquire, release, pin and unpin requests over the input stream. A
// behavioral copy of the slot table (tags, valid bits, counts, ranks)
// predicts every result word. The bench checks each word field by field, in
// order. Random gaps on both sides, one long output stall to fill the block.
// ----------------------------------------------------------------------------
module tb_lru_block_buffer_cache_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = lbc_pkg::SLOT_COUNT_DEF;
	localparam int RX_HOLD_CYCLES = 240;
	localparam int DRAIN_CYCLES   = 2 * SLOTS + 16;
	// worst case ~2000 words at acquire latency plus long gaps on both sides
	localparam int CYCLE_LIMIT    = 1_500_000;
	localparam int POOL_SIZE      = 16;

	typedef struct packed {
		logic [lbc_pkg::SLOT_W-1:0] slot;
		logic                       hit;
		logic                       need_read;
		lbc_pkg::status_t           status;
	} slot_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	// [1:0] func, [9:2] device_id, [41:10] block_number, [46:42] slot_index
	logic [lbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	// [4:0] slot_out, [5] hit, [6] need_read, [8:7] status
	logic [lbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// behavioral slot table
	logic [lbc_pkg::DEV_W-1:0]  cache_tag_dev [SLOTS];
	logic [lbc_pkg::BLK_W-1:0]  cache_tag_blk [SLOTS];
	logic                       cache_valid   [SLOTS];
	logic [lbc_pkg::CNT_W-1:0]  cache_refs    [SLOTS];
	logic [lbc_pkg::SLOT_W-1:0] cache_rank    [SLOTS];

	slot_result_t pending_results[$];
	slot_result_t last_predicted;
	logic [lbc_pkg::DEV_W-1:0] pool_dev [POOL_SIZE];
	logic [lbc_pkg::BLK_W-1:0] pool_blk [POOL_SIZE];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned rx_hold_reqs = 0;
	bit          no_gaps;

	lru_block_buffer_cache_unit #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lru_block_buffer_cache_unit: mismatch");
			$finish;
		end
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Apply one request to the slot table and return the word it produces.
	function automatic slot_result_t apply_cache_op(input lbc_pkg::func_t op,
			input logic [lbc_pkg::DEV_W-1:0] dev, input logic [lbc_pkg::BLK_W-1:0] blk,
			input logic [lbc_pkg::SLOT_W-1:0] slot);
		slot_result_t r;
		int best;
		int i;
		logic [lbc_pkg::SLOT_W-1:0] old_rank;
		best = -1;
		r = '{slot: slot, hit: 1'b0, need_read: 1'b0, status: lbc_pkg::STAT_OK};
		case (op)
			lbc_pkg::FUNC_ACQUIRE: begin
				// most recent matching tag wins
				for (i = 0; i < SLOTS; i++)
					if (cache_tag_dev[i] == dev && cache_tag_blk[i] == blk &&
							(best < 0 || cache_rank[i] < cache_rank[best]))
						best = i;
				if (best >= 0) begin
					r.slot = best[lbc_pkg::SLOT_W-1:0];
					r.hit = 1'b1;
					if (cache_refs[best] == lbc_pkg::CNT_MAX) begin
						r.status = lbc_pkg::STAT_OVERFLOW;
					end else begin
						cache_refs[best] = cache_refs[best] + 1'b1;
						r.need_read = !cache_valid[best];
						cache_valid[best] = 1'b1;
					end
				end else begin
					// recycle the least recent idle slot
					for (i = 0; i < SLOTS; i++)
						if (cache_refs[i] == '0 && (best < 0 || cache_rank[i] > cache_rank[best]))
							best = i;
					if (best < 0) begin
						r.slot = '0;
						r.status = lbc_pkg::STAT_NO_FREE;
					end else begin
						cache_tag_dev[best] = dev;
						cache_tag_blk[best] = blk;
						cache_refs[best] = lbc_pkg::CNT_W'(1);
						cache_valid[best] = 1'b1;
						r.slot = best[lbc_pkg::SLOT_W-1:0];
						r.need_read = 1'b1;
					end
				end
			end
			lbc_pkg::FUNC_PIN: begin
				if (cache_refs[slot] == lbc_pkg::CNT_MAX)
					r.status = lbc_pkg::STAT_OVERFLOW;
				else
					cache_refs[slot] = cache_refs[slot] + 1'b1;
			end
			default: begin
				if (cache_refs[slot] == '0) begin
					r.status = lbc_pkg::STAT_UNDERFLOW;
				end else begin
					cache_refs[slot] = cache_refs[slot] - 1'b1;
					if (op == lbc_pkg::FUNC_RELEASE && cache_refs[slot] == '0) begin
						old_rank = cache_rank[slot];
						for (i = 0; i < SLOTS; i++)
							if (cache_rank[i] < old_rank)
								cache_rank[i] = cache_rank[i] + 1'b1;
						cache_rank[slot] = '0;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Enter and leave at a falling edge; tvalid stays high on return.
	task automatic issue_request(input lbc_pkg::func_t op,
			input logic [lbc_pkg::DEV_W-1:0] dev, input logic [lbc_pkg::BLK_W-1:0] blk,
			input logic [lbc_pkg::SLOT_W-1:0] slot);
		int unsigned gap;
		if (!no_gaps && $urandom_range(0, 2) == 0) begin
			gap = gap_len();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {1'b0, slot, blk, dev, op};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		last_predicted = apply_cache_op(op, dev, blk, slot);
		pending_results.push_back(last_predicted);
		@(negedge clk);
	endtask

	function automatic logic [lbc_pkg::SLOT_W-1:0] pick_held_slot();
		int held[$];
		int i;
		for (i = 0; i < SLOTS; i++)
			if (cache_refs[i] != '0)
				held.push_back(i);
		if (held.size() == 0 || $urandom_range(0, 9) == 0)
			return lbc_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
		return lbc_pkg::SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
	endfunction

	function automatic int idle_slots();
		int i;
		int n;
		n = 0;
		for (i = 0; i < SLOTS; i++)
			if (cache_refs[i] == '0)
				n++;
		return n;
	endfunction

	task automatic release_everything();
		int i;
		for (i = 0; i < SLOTS; i++)
			while (cache_refs[i] != '0)
				issue_request(lbc_pkg::FUNC_RELEASE, '0, '0, i[lbc_pkg::SLOT_W-1:0]);
	endtask

	// Fresh table: every slot is tagged device 0 block 0, none valid.
	task automatic test_reset_state();
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h00, 32'h0000_0000, 5'd31);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'hAA, 32'h5555_5555, 5'd10);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h55, 32'hAAAA_AAAA, 5'd21);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
		issue_request(lbc_pkg::FUNC_UNPIN, 8'h00, 32'h0000_0000, 5'd0);
		issue_request(lbc_pkg::FUNC_UNPIN, 8'h00, 32'h0000_0000, 5'd0);
		issue_request(lbc_pkg::FUNC_PIN, 8'h00, 32'h0000_0000, 5'd1);
		issue_request(lbc_pkg::FUNC_UNPIN, 8'h00, 32'h0000_0000, 5'd1);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd1);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd2);
		issue_request(lbc_pkg::FUNC_PIN, 8'h00, 32'h0000_0000, 5'd17);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd17);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd7);
		release_everything();
	endtask

	// Hold every slot, then ask for one more block and for one already held.
	task automatic test_no_free_buffer();
		int n;
		n = 0;
		while (idle_slots() != 0) begin
			issue_request(lbc_pkg::FUNC_ACQUIRE, 8'hC0 | n[lbc_pkg::DEV_W-1:0], $urandom,
				lbc_pkg::SLOT_W'($urandom));
			n++;
		end
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h3F, 32'h1234_5678, 5'd0);
		issue_request(lbc_pkg::FUNC_ACQUIRE, cache_tag_dev[5], cache_tag_blk[5], 5'd5);
		release_everything();
	endtask

	// Walk one count up to the top and back down past zero.
	task automatic test_count_limits();
		logic [lbc_pkg::BLK_W-1:0] blk;
		logic [lbc_pkg::SLOT_W-1:0] s;
		blk = $urandom;
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h3C, blk, 5'd0);
		s = last_predicted.slot;
		while (cache_refs[s] != lbc_pkg::CNT_MAX)
			issue_request(lbc_pkg::FUNC_PIN, 8'h00, 32'h0, s);
		issue_request(lbc_pkg::FUNC_PIN, 8'h00, 32'h0, s);
		issue_request(lbc_pkg::FUNC_ACQUIRE, 8'h3C, blk, s);
		while (cache_refs[s] != '0)
			issue_request(lbc_pkg::FUNC_UNPIN, 8'h00, 32'h0, s);
		issue_request(lbc_pkg::FUNC_UNPIN, 8'h00, 32'h0, s);
		issue_request(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0, s);
	endtask

	// Stall the output long enough that the block stops taking words.
	task automatic test_output_backpressure();
		int k;
		no_gaps = 1'b1;
		rx_hold_reqs++;
		for (k = 0; k < 12; k++)
			issue_request(lbc_pkg::func_t'($urandom_range(0, 3)),
				lbc_pkg::DEV_W'($urandom_range(0, 3)), lbc_pkg::BLK_W'($urandom_range(0, 3)),
				pick_held_slot());
		no_gaps = 1'b0;
		release_everything();
	endtask

	task automatic test_random_traffic();
		int seg;
		int k;
		int roll;
		int acq_pct;
		int p;
		for (p = 0; p < POOL_SIZE; p++) begin
			pool_dev[p] = lbc_pkg::DEV_W'($urandom);
			pool_blk[p] = $urandom;
		end
		for (seg = 0; seg < 13; seg++) begin
			acq_pct = $urandom_range(20, 75);
			no_gaps = ($urandom_range(0, 4) == 0);
			for (k = 0; k < 100; k++) begin
				if ($urandom_range(0, 49) == 0) begin
					p = $urandom_range(0, POOL_SIZE - 1);
					pool_dev[p] = lbc_pkg::DEV_W'($urandom);
					pool_blk[p] = $urandom;
				end
				roll = $urandom_range(0, 99);
				if (roll < acq_pct) begin
					if ($urandom_range(0, 5) == 0) begin
						issue_request(lbc_pkg::FUNC_ACQUIRE, lbc_pkg::DEV_W'($urandom), $urandom,
							lbc_pkg::SLOT_W'($urandom));
					end else begin
						p = $urandom_range(0, POOL_SIZE - 1);
						issue_request(lbc_pkg::FUNC_ACQUIRE, pool_dev[p], pool_blk[p],
							lbc_pkg::SLOT_W'($urandom));
					end
				end else if (roll < acq_pct + (100 - acq_pct) * 6 / 10) begin
					issue_request(lbc_pkg::FUNC_RELEASE, lbc_pkg::DEV_W'($urandom), $urandom,
						pick_held_slot());
				end else if (roll < acq_pct + (100 - acq_pct) * 8 / 10) begin
					issue_request(lbc_pkg::FUNC_PIN, lbc_pkg::DEV_W'($urandom), $urandom,
						pick_held_slot());
				end else begin
					issue_request(lbc_pkg::FUNC_UNPIN, lbc_pkg::DEV_W'($urandom), $urandom,
						pick_held_slot());
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// output ready: random gaps, or one long hold on request
	initial begin : rx_ready_proc
		int unsigned rx_idle;
		int unsigned holds_done;
		rx_idle = 0;
		holds_done = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_reqs != holds_done) begin
				holds_done = rx_hold_reqs;
				rx_idle = RX_HOLD_CYCLES;
			end else if (rx_idle == 0 && !no_gaps && $urandom_range(0, 3) == 0) begin
				rx_idle = gap_len();
			end
			if (rx_idle > 0) begin
				m_axis_tready <= 1'b0;
				rx_idle--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		slot_result_t want;
		slot_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{slot: m_axis_tdata[4:0], hit: m_axis_tdata[5], need_read: m_axis_tdata[6],
				status: lbc_pkg::status_t'(m_axis_tdata[8:7])};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, got slot %0d hit %0d need_read %0d status %0d",
					$time, got.slot, got.hit, got.need_read, got.status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.slot !== want.slot) begin
					$display("%0t: slot_out expected %0d got %0d", $time, want.slot, got.slot);
					mismatch_count++;
				end
				if (got.hit !== want.hit) begin
					$display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
					mismatch_count++;
				end
				if (got.need_read !== want.need_read) begin
					$display("%0t: need_read expected %0d got %0d", $time, want.need_read,
						got.need_read);
					mismatch_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : run_tests
		int i;
		no_gaps = 1'b0;
		for (i = 0; i < SLOTS; i++) begin
			cache_tag_dev[i] = '0;
			cache_tag_blk[i] = '0;
			cache_valid[i] = 1'b0;
			cache_refs[i] = '0;
			cache_rank[i] = lbc_pkg::SLOT_W'(SLOTS - 1 - i);
		end
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_no_free_buffer();
		test_count_limits();
		test_output_backpressure();
		test_random_traffic();

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("lru_block_buffer_cache_unit: match");
		else
			$display("lru_block_buffer_cache_unit: mismatch");
		$finish;
	end

endmodule

// ----- lru_block_buffer_cache_unit.f -----
rtl/lbc_pkg.sv
rtl/lbc_ctrl.sv
rtl/lbc_dpath.sv
rtl/lru_block_buffer_cache_unit.sv
sim/tb_lru_block_buffer_cache_unit.sv
